// ===== hw/rtl/rar_pkg.sv =====
// rar_pkg: shared constants and types for the rational arithmetic unit
// no dependencies
`default_nettype none
package rar_pkg;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_RED = 3'd4
    } t_op;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== hw/rtl/rar_divider.sv =====
// rar_divider: unsigned restoring divider, one quotient bit per cycle
// depends on rar_pkg
`default_nettype none
module rar_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rar_pkg::WORD_BITS-1:0] i_dividend,
    input  wire logic [rar_pkg::WORD_BITS-1:0] i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic      [rar_pkg::WORD_BITS-1:0] o_quot,
    output logic      [rar_pkg::WORD_BITS-1:0] o_rem
);
    localparam int W = rar_pkg::WORD_BITS;

    logic [W-1:0] r_quot, r_div;
    logic [W:0]   r_rem;
    logic [rar_pkg::CNT_BITS-1:0] r_cnt;
    logic r_busy, r_done;
    logic [W:0] w_shift, w_sub;

    assign w_shift = {r_rem[W-1:0], r_quot[W-1]};
    assign w_sub   = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rar_pkg::CNT_BITS'(W);
                r_quot <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_sub[W]) begin
                    r_rem  <= w_sub;
                    r_quot <= {r_quot[W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rar_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[W-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("done without busy");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div != '0) |-> (r_rem[W-1:0] < r_div))
        else $error("partial remainder overflow");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while busy");
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arith_reduce_unit.sv =====
// rational_arith_reduce_unit: rational add/sub/mul/div and euclid gcd reduction
// depends on rar_pkg and rar_divider
// add/sub: three products, mul/div: two; each product is summed from three partial products
// on one shared 32x32 multiplier, then the sum is used
// reduce: one divider pass per euclid step and per quotient (start, one divide step per
// bit, done); unused opcodes answer in the cycle after accept
// one transaction at a time, not ready meanwhile, ready again after the result is taken
// synchronous active-low reset clears the sequencer and output valid
`default_nettype none
module rational_arith_reduce_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [63:0] i_a_num,
    input  wire logic [63:0] i_a_den,
    input  wire logic [63:0] i_b_num,
    input  wire logic [63:0] i_b_den,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_res_num,
    output logic [63:0]      o_res_den,
    output logic             o_zero_den_error
);
    localparam int W = rar_pkg::WORD_BITS;
    localparam int H = W / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_GCD, S_GWAIT, S_QN, S_QNW, S_QD, S_QDW, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]   r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd, r_p0, r_x, r_y, r_g, r_qn, r_rn, r_rd;
    logic         r_negn, r_negd, r_err;
    logic [1:0]   r_mph;
    logic [W-1:0] r_macc;
    logic [W-1:0] w_ma, w_mb, w_prod, w_dvd, w_dvs, w_quot, w_rem, w_mn, w_md;
    logic [H-1:0] w_mx, w_my;
    logic [W-1:0] w_pp;
    rar_pkg::t_div_ctl w_dctl;

    function automatic logic [63:0] sext(input logic [W-1:0] v);
        return 64'($signed(v));
    endfunction

    assign w_mn = r_an[W-1] ? (W'(0) - r_an) : r_an;
    assign w_md = r_ad[W-1] ? (W'(0) - r_ad) : r_ad;

    always_comb begin
        unique case (r_state)
            S_M0:    begin w_ma = r_an; w_mb = (r_op == rar_pkg::OP_MUL) ? r_bn : r_bd; end
            S_M1:    begin w_ma = r_bn; w_mb = r_ad; end
            default: begin w_ma = r_ad; w_mb = (r_op == rar_pkg::OP_DIV) ? r_bn : r_bd; end
        endcase
    end

    // low word of the product from three half-width partial products
    always_comb begin
        unique case (r_mph)
            2'd1:    begin w_mx = w_ma[H-1:0]; w_my = w_mb[W-1:H]; end
            2'd2:    begin w_mx = w_ma[W-1:H]; w_my = w_mb[H-1:0]; end
            default: begin w_mx = w_ma[H-1:0]; w_my = w_mb[H-1:0]; end
        endcase
    end
    assign w_pp   = W'(w_mx) * W'(w_my);
    assign w_prod = r_macc;

    always_comb begin
        unique case (r_state)
            S_QN:    begin w_dvd = r_x; w_dvs = r_g; end
            S_QD:    begin w_dvd = r_y; w_dvs = r_g; end
            default: begin w_dvd = r_x; w_dvs = r_y; end
        endcase
    end
    assign w_dctl.start = (r_state == S_GCD && r_y != '0) || r_state == S_QN
                          || r_state == S_QD;

    rar_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dctl.start),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_busy(w_dctl.busy), .o_done(w_dctl.done), .o_quot(w_quot), .o_rem(w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mph   <= '0;
        end else begin
            if (r_state == S_M0 || r_state == S_M1 || r_state == S_M2) begin
                r_mph <= r_mph + 2'd1;
                if (r_mph == 2'd0) r_macc <= w_pp;
                else if (r_mph != 2'd3) r_macc <= r_macc + {w_pp[H-1:0], H'(0)};
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op <= i_opcode;
                    r_an <= i_a_num[W-1:0];
                    r_ad <= i_a_den[W-1:0];
                    r_bn <= i_b_num[W-1:0];
                    r_bd <= i_b_den[W-1:0];
                    r_rn <= '0;
                    r_rd <= W'(1);
                    r_err <= 1'b0;
                    if (i_opcode == rar_pkg::OP_RED) r_state <= S_M3;
                    else if (i_opcode > rar_pkg::OP_RED) r_state <= S_OUT;
                    else r_state <= S_M0;
                end
                S_M0: if (r_mph == 2'd3) begin
                    r_p0 <= w_prod;
                    if (r_op == rar_pkg::OP_MUL || r_op == rar_pkg::OP_DIV) begin
                        r_rn <= w_prod; r_state <= S_M2;
                    end else r_state <= S_M1;
                end
                S_M1: if (r_mph == 2'd3) begin
                    r_rn <= (r_op == rar_pkg::OP_ADD) ? r_p0 + w_prod : r_p0 - w_prod;
                    r_state <= S_M2;
                end
                S_M2: if (r_mph == 2'd3) begin r_rd <= w_prod; r_state <= S_OUT; end
                S_M3: begin
                    r_negn <= r_an[W-1];
                    r_negd <= r_ad[W-1];
                    if (r_ad == '0) begin r_err <= 1'b1; r_state <= S_OUT; end
                    else if (r_an == '0) r_state <= S_OUT;
                    else begin
                        r_x <= w_mn; r_y <= w_md; r_qn <= w_mn; r_g <= w_md;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: if (r_y == '0) begin
                    r_g <= r_x; r_x <= r_qn; r_y <= r_g; r_state <= S_QN;
                end else r_state <= S_GWAIT;
                S_GWAIT: if (w_dctl.done) begin
                    r_x <= r_y; r_y <= w_rem; r_state <= S_GCD;
                end
                S_QN:  r_state <= S_QNW;
                S_QNW: if (w_dctl.done) begin
                    r_rn <= r_negn ? W'(0) - w_quot : w_quot; r_state <= S_QD;
                end
                S_QD:  r_state <= S_QDW;
                S_QDW: if (w_dctl.done) begin
                    r_rd <= r_negd ? W'(0) - w_quot : w_quot; r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_res_num        = sext(r_rn);
    assign o_res_den        = sext(r_rd);
    assign o_zero_den_error = r_err;

    a_err_only_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_den_error) |-> (r_op == rar_pkg::OP_RED && r_rd == W'(1)))
        else $error("error flag outside reduce");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_rn) && $stable(r_rd)))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
